@@ src/owbl_pkg.sv @@
// shared types and constants of the one-wire backlight level encoder
`default_nettype none

package owbl_pkg;

    localparam int OWBL_CHIP_LEVELS = 31;
    localparam int OWBL_Q_DEPTH     = 2;
    localparam int OWBL_US_W        = 10;
    localparam int OWBL_HOLD_W      = 11;
    localparam int OWBL_BYTE_W      = 8;
    localparam int OWBL_CFG_IDX_W   = 3;
    localparam int OWBL_PCT_FULL    = 100;
    localparam int OWBL_PCT_SCALE   = 10000;

    typedef enum logic [OWBL_CFG_IDX_W-1:0] {
        REG_DETECT_DELAY = 3'd0,
        REG_DETECT_LOW   = 3'd1,
        REG_MODE_WINDOW  = 3'd2,
        REG_START        = 3'd3,
        REG_END_LOW      = 3'd4,
        REG_SHORT        = 3'd5,
        REG_LONG         = 3'd6,
        REG_DEV_ADDR     = 3'd7
    } t_reg_idx;

    localparam logic [OWBL_US_W-1:0]   RST_DETECT_DELAY = 10'd150;
    localparam logic [OWBL_US_W-1:0]   RST_DETECT_LOW   = 10'd350;
    localparam logic [OWBL_US_W-1:0]   RST_MODE_WINDOW  = 10'd800;
    localparam logic [OWBL_US_W-1:0]   RST_START        = 10'd50;
    localparam logic [OWBL_US_W-1:0]   RST_END_LOW      = 10'd50;
    localparam logic [OWBL_US_W-1:0]   RST_SHORT        = 10'd50;
    localparam logic [OWBL_US_W-1:0]   RST_LONG         = 10'd100;
    localparam logic [OWBL_BYTE_W-1:0] RST_DEV_ADDR     = 8'h72;

    typedef struct packed {
        logic [OWBL_US_W-1:0]   detect_delay_us;
        logic [OWBL_US_W-1:0]   detect_low_us;
        logic [OWBL_US_W-1:0]   mode_window_us;
        logic [OWBL_US_W-1:0]   start_us;
        logic [OWBL_US_W-1:0]   end_low_us;
        logic [OWBL_US_W-1:0]   short_us;
        logic [OWBL_US_W-1:0]   long_us;
        logic [OWBL_BYTE_W-1:0] device_address;
    } t_cfg;

    // level queue head as seen by the sequencer
    typedef struct packed {
        logic                   valid;
        logic [OWBL_BYTE_W-1:0] level;
    } t_lvl_head;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_DLOW  = 10'b00_0000_0010,
        ST_MODE  = 10'b00_0000_0100,
        ST_ABIT  = 10'b00_0000_1000,
        ST_AEND  = 10'b00_0001_0000,
        ST_START = 10'b00_0010_0000,
        ST_LBIT  = 10'b00_0100_0000,
        ST_LEND  = 10'b00_1000_0000,
        ST_FIN   = 10'b01_0000_0000,
        ST_SPARE = 10'b10_0000_0000
    } t_state;

endpackage

`default_nettype wire

@@ src/owbl_front.sv @@
// front end: maps percent to chip level and queues levels for the sequencer
`default_nettype none

module owbl_front
    import owbl_pkg::*;
#(
    parameter int CHIP_LEVELS = OWBL_CHIP_LEVELS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    output logic                        o_full,
    input  wire logic [OWBL_BYTE_W-1:0] i_percent,
    output t_lvl_head                   o_head,
    input  wire logic                   i_take
);

    localparam int Divisor = OWBL_PCT_SCALE / CHIP_LEVELS;
    localparam int PtrW    = $clog2(OWBL_Q_DEPTH);
    localparam int CntW    = $clog2(OWBL_Q_DEPTH + 1);
    localparam int NumPct  = 2 ** OWBL_BYTE_W;

    // constant level table, one entry per percent code
    logic [OWBL_BYTE_W-1:0] w_tab [NumPct];

    for (genvar g = 0; g < NumPct; g++) begin : g_tab
        localparam int Lv = (g >= OWBL_PCT_FULL) ? CHIP_LEVELS :
                            (g == 0) ? 0 : ((OWBL_PCT_FULL * g) / Divisor + 1);
        assign w_tab[g] = OWBL_BYTE_W'(Lv);
    end

    logic [OWBL_BYTE_W-1:0] r_q [OWBL_Q_DEPTH];
    logic [PtrW-1:0]        r_wptr, r_rptr;
    logic [CntW-1:0]        r_cnt;
    logic                   w_put, w_get;

    assign o_full = (r_cnt == CntW'(OWBL_Q_DEPTH));
    assign w_put  = i_push && !o_full;
    assign w_get  = i_take && (r_cnt != '0);

    assign o_head.valid = (r_cnt != '0);
    assign o_head.level = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_q[r_wptr] <= w_tab[i_percent];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_put) begin
                r_wptr <= (r_wptr == PtrW'(OWBL_Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_get) begin
                r_rptr <= (r_rptr == PtrW'(OWBL_Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_put && !w_get) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_get && !w_put) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/owbl_back.sv @@
// back end: segment sequencer with one-entry result register
`default_nettype none

module owbl_back
    import owbl_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cfg                   i_cfg,
    input  wire t_lvl_head              i_head,
    output logic                        o_take,
    input  wire logic                   i_pop,
    output logic                        o_empty,
    output logic                        o_pin_high,
    output logic [OWBL_HOLD_W-1:0]      o_hold_us,
    output logic                        o_last
);

    t_state                 r_state, n_state;
    logic [3:0]             r_cnt, n_cnt;
    logic [OWBL_BYTE_W-1:0] r_lvl, n_lvl;
    logic                   r_valid;
    logic                   r_pin, r_last;
    logic [OWBL_HOLD_W-1:0] r_hold;

    logic                   w_adv, w_emit;
    logic                   e_pin, e_last;
    logic [OWBL_HOLD_W-1:0] e_hold;
    logic [OWBL_BYTE_W-1:0] w_byte;
    logic                   w_bit, w_phase;
    logic [OWBL_HOLD_W-1:0] w_bit_hold;

    // result register frees up when empty or being popped
    assign w_adv   = !r_valid || i_pop;
    assign o_empty = !r_valid;
    assign o_pin_high = r_pin;
    assign o_hold_us  = r_hold;
    assign o_last     = r_last;

    assign w_byte     = (r_state == ST_ABIT) ? i_cfg.device_address : r_lvl;
    assign w_bit      = w_byte[~r_cnt[3:1]];
    assign w_phase    = r_cnt[0];
    // a one is short low then long high, a zero the reverse
    assign w_bit_hold = (w_bit ^ w_phase) ? {1'b0, i_cfg.short_us} : {1'b0, i_cfg.long_us};

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_lvl   = r_lvl;
        o_take  = 1'b0;
        w_emit  = 1'b0;
        e_pin   = 1'b0;
        e_hold  = '0;
        e_last  = 1'b0;
        if (w_adv) begin
            case (r_state)
                ST_IDLE: begin
                    if (i_head.valid) begin
                        o_take = 1'b1;
                        w_emit = 1'b1;
                        if (i_head.level == '0) begin
                            e_last = 1'b1;
                        end else begin
                            e_pin   = 1'b1;
                            e_hold  = {1'b0, i_cfg.detect_delay_us};
                            n_lvl   = i_head.level;
                            n_state = ST_DLOW;
                        end
                    end
                end
                ST_DLOW: begin
                    w_emit  = 1'b1;
                    e_hold  = {1'b0, i_cfg.detect_low_us};
                    n_state = ST_MODE;
                end
                ST_MODE: begin
                    w_emit  = 1'b1;
                    e_pin   = 1'b1;
                    e_hold  = {1'b0, i_cfg.mode_window_us} + {1'b0, i_cfg.start_us};
                    n_cnt   = '0;
                    n_state = ST_ABIT;
                end
                ST_ABIT, ST_LBIT: begin
                    w_emit = 1'b1;
                    e_pin  = w_phase;
                    e_hold = w_bit_hold;
                    n_cnt  = r_cnt + 1'b1;
                    if (r_cnt == 4'hf) begin
                        n_state = (r_state == ST_ABIT) ? ST_AEND : ST_LEND;
                    end
                end
                ST_AEND: begin
                    w_emit  = 1'b1;
                    e_hold  = {1'b0, i_cfg.end_low_us};
                    n_state = ST_START;
                end
                ST_START: begin
                    w_emit  = 1'b1;
                    e_pin   = 1'b1;
                    e_hold  = {1'b0, i_cfg.start_us};
                    n_cnt   = '0;
                    n_state = ST_LBIT;
                end
                ST_LEND: begin
                    w_emit  = 1'b1;
                    e_hold  = {1'b0, i_cfg.end_low_us};
                    n_state = ST_FIN;
                end
                ST_FIN: begin
                    w_emit  = 1'b1;
                    e_pin   = 1'b1;
                    e_last  = 1'b1;
                    n_state = ST_IDLE;
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_adv) begin
                r_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl <= n_lvl;
        if (w_adv && w_emit) begin
            r_pin  <= e_pin;
            r_hold <= e_hold;
            r_last <= e_last;
        end
    end

    a_last_zero_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> (r_hold == '0))
        else $error("final segment with nonzero hold");

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> (r_state == ST_IDLE && i_head.valid))
        else $error("level taken while sequencing");

    a_seq_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && n_state == ST_DLOW) |=> (r_lvl != '0))
        else $error("sequence started for level zero");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_pop) |=> ($stable(r_state) && $stable(r_cnt)))
        else $error("sequencer advanced during output stall");

    a_bits_continue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ABIT && r_cnt != 4'hf && w_adv) |=> (r_state == ST_ABIT))
        else $error("address bits cut short");

endmodule

`default_nettype wire

@@ src/one_wire_backlight_level_encoder_core.sv @@
// top level: configuration registers, level front end and segment sequencer
// a request is written into the level queue, then its first segment into the result register
// throughput: one segment per cycle while the result register is empty or popped;
// a nonzero level takes 39 segments, a zero level one segment
// a two-entry level queue lets requests be taken while a sequence is running
// synchronous active-low reset restores register defaults and empties the queues
`default_nettype none

module one_wire_backlight_level_encoder_core
    import owbl_pkg::*;
#(
    parameter int CHIP_LEVELS = OWBL_CHIP_LEVELS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [OWBL_CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [OWBL_US_W-1:0]      i_cfg_data,
    input  wire logic                      push,
    output logic                           full,
    input  wire logic [OWBL_BYTE_W-1:0]    i_percent,
    output logic                           empty,
    input  wire logic                      pop,
    output logic                           o_pin_high,
    output logic [OWBL_HOLD_W-1:0]         o_hold_us,
    output logic                           o_last
);

    t_cfg      r_cfg;
    t_lvl_head w_head;
    logic      w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.detect_delay_us <= RST_DETECT_DELAY;
            r_cfg.detect_low_us   <= RST_DETECT_LOW;
            r_cfg.mode_window_us  <= RST_MODE_WINDOW;
            r_cfg.start_us        <= RST_START;
            r_cfg.end_low_us      <= RST_END_LOW;
            r_cfg.short_us        <= RST_SHORT;
            r_cfg.long_us         <= RST_LONG;
            r_cfg.device_address  <= RST_DEV_ADDR;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_DETECT_DELAY: r_cfg.detect_delay_us <= i_cfg_data;
                REG_DETECT_LOW:   r_cfg.detect_low_us   <= i_cfg_data;
                REG_MODE_WINDOW:  r_cfg.mode_window_us  <= i_cfg_data;
                REG_START:        r_cfg.start_us        <= i_cfg_data;
                REG_END_LOW:      r_cfg.end_low_us      <= i_cfg_data;
                REG_SHORT:        r_cfg.short_us        <= i_cfg_data;
                REG_LONG:         r_cfg.long_us         <= i_cfg_data;
                REG_DEV_ADDR:     r_cfg.device_address  <= i_cfg_data[OWBL_BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    owbl_front #(
        .CHIP_LEVELS (CHIP_LEVELS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_percent (i_percent),
        .o_head    (w_head),
        .i_take    (w_take)
    );

    owbl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_head     (w_head),
        .o_take     (w_take),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_pin_high (o_pin_high),
        .o_hold_us  (o_hold_us),
        .o_last     (o_last)
    );

endmodule

`default_nettype wire

@@ sim/one_wire_backlight_level_encoder_core_tb.sv @@
// self-checking testbench for the one-wire backlight level encoder core
module one_wire_backlight_level_encoder_core_tb;
    import owbl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEVEL_FULL     = 31;
    localparam int PCT_SATURATE   = 100;
    localparam int PCT_STEP       = 10000 / LEVEL_FULL;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_SET  = 20;
    localparam int MAX_REPORTS    = 60;
    localparam int N_ROWS         = 19;

    typedef struct packed {
        logic                   pin_high;
        logic [OWBL_HOLD_W-1:0] hold_us;
        logic                   last;
    } t_segment;

    typedef struct packed {
        logic [OWBL_BYTE_W-1:0] pct;
        logic                   lvl_known;
        logic [OWBL_BYTE_W-1:0] lvl;
    } t_pct_row;

    // levels given only where they follow directly from the mapping
    localparam t_pct_row DIRECTED_ROWS [N_ROWS] = '{
        '{8'd0,   1'b1, 8'd0},
        '{8'd1,   1'b1, 8'd1},
        '{8'd2,   1'b0, 8'd0},
        '{8'd3,   1'b0, 8'd0},
        '{8'd4,   1'b0, 8'd0},
        '{8'd8,   1'b0, 8'd0},
        '{8'd16,  1'b0, 8'd0},
        '{8'd32,  1'b0, 8'd0},
        '{8'd50,  1'b0, 8'd0},
        '{8'd64,  1'b0, 8'd0},
        '{8'd98,  1'b0, 8'd0},
        '{8'd99,  1'b0, 8'd0},
        '{8'd100, 1'b1, 8'd31},
        '{8'd101, 1'b1, 8'd31},
        '{8'd127, 1'b1, 8'd31},
        '{8'd128, 1'b1, 8'd31},
        '{8'd200, 1'b1, 8'd31},
        '{8'd254, 1'b1, 8'd31},
        '{8'd255, 1'b1, 8'd31}
    };

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [OWBL_CFG_IDX_W-1:0] i_cfg_addr;
    logic [OWBL_US_W-1:0]      i_cfg_data;
    logic                      push;
    logic                      full;
    logic [OWBL_BYTE_W-1:0]    i_percent;
    logic                      empty;
    logic                      pop;
    logic                      o_pin_high;
    logic [OWBL_HOLD_W-1:0]    o_hold_us;
    logic                      o_last;

    t_cfg           timing;
    t_segment       segments_due [$];
    logic [9:0]     reg_plan [8];
    bit             steady_flow;
    int             n_err;
    int             idle_cycles;

    one_wire_backlight_level_encoder_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_percent  (i_percent),
        .empty      (empty),
        .pop        (pop),
        .o_pin_high (o_pin_high),
        .o_hold_us  (o_hold_us),
        .o_last     (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int draw_gap();
        return steady_flow ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic logic [OWBL_BYTE_W-1:0] chip_level(logic [OWBL_BYTE_W-1:0] pct);
        int lvl;
        if (pct >= PCT_SATURATE)
            lvl = LEVEL_FULL;
        else if (pct == 0)
            lvl = 0;
        else
            lvl = (100 * int'(pct)) / PCT_STEP + 1;
        return lvl[OWBL_BYTE_W-1:0];
    endfunction

    function automatic void add_segment(logic pin, logic [OWBL_HOLD_W-1:0] hold, logic fin);
        t_segment s;
        s.pin_high = pin;
        s.hold_us  = hold;
        s.last     = fin;
        segments_due.push_back(s);
    endfunction

    // msb first; a one is short low then long high
    function automatic void add_byte(logic [OWBL_BYTE_W-1:0] b);
        for (int i = OWBL_BYTE_W - 1; i >= 0; i--) begin
            if (b[i]) begin
                add_segment(1'b0, {1'b0, timing.short_us}, 1'b0);
                add_segment(1'b1, {1'b0, timing.long_us}, 1'b0);
            end else begin
                add_segment(1'b0, {1'b0, timing.long_us}, 1'b0);
                add_segment(1'b1, {1'b0, timing.short_us}, 1'b0);
            end
        end
        add_segment(1'b0, {1'b0, timing.end_low_us}, 1'b0);
    endfunction

    function automatic void plan_waveform(logic [OWBL_BYTE_W-1:0] lvl);
        if (lvl == 0) begin
            add_segment(1'b0, '0, 1'b1);
        end else begin
            add_segment(1'b1, {1'b0, timing.detect_delay_us}, 1'b0);
            add_segment(1'b0, {1'b0, timing.detect_low_us}, 1'b0);
            // mode window merges with the first start bit
            add_segment(1'b1, {1'b0, timing.mode_window_us} + {1'b0, timing.start_us}, 1'b0);
            add_byte(timing.device_address);
            add_segment(1'b1, {1'b0, timing.start_us}, 1'b0);
            add_byte(lvl);
            add_segment(1'b1, '0, 1'b1);
        end
    endfunction

    task automatic set_reg(t_reg_idx idx, logic [OWBL_US_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_DETECT_DELAY: timing.detect_delay_us = val;
            REG_DETECT_LOW:   timing.detect_low_us   = val;
            REG_MODE_WINDOW:  timing.mode_window_us  = val;
            REG_START:        timing.start_us        = val;
            REG_END_LOW:      timing.end_low_us      = val;
            REG_SHORT:        timing.short_us        = val;
            REG_LONG:         timing.long_us         = val;
            REG_DEV_ADDR:     timing.device_address  = val[OWBL_BYTE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_regs();
        for (int k = 0; k < 8; k++)
            set_reg(t_reg_idx'(k), reg_plan[k]);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_pct(logic [OWBL_BYTE_W-1:0] pct, logic lvl_known,
                            logic [OWBL_BYTE_W-1:0] lvl);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_percent <= pct;
        do @(posedge i_clk); while (full !== 1'b0);
        plan_waveform(lvl_known ? lvl : chip_level(pct));
    endtask

    task automatic send_random(int count);
        logic [OWBL_BYTE_W-1:0] pct;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 7))
                0:       pct = '0;
                1:       pct = OWBL_BYTE_W'($urandom_range(PCT_SATURATE, 255));
                2:       pct = OWBL_BYTE_W'($urandom_range(90, 110));
                default: pct = OWBL_BYTE_W'($urandom_range(0, 255));
            endcase
            send_pct(pct, 1'b0, '0);
        end
    endtask

    // hold off until every segment has drained, then let the sequencer finish
    task automatic settle();
        push <= 1'b0;
        while (segments_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic report(string what, int expv, logic [OWBL_HOLD_W-1:0] gotv);
        n_err++;
        if (n_err <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, expv, gotv);
    endtask

    // result side
    initial begin
        t_segment exp_seg;
        int gap;
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty !== 1'b0);
            if (segments_due.size() == 0) begin
                n_err++;
                if (n_err <= MAX_REPORTS)
                    $display("%0t: unexpected segment, pin %0d hold %0d last %0d",
                             $time, o_pin_high, o_hold_us, o_last);
            end else begin
                exp_seg = segments_due.pop_front();
                if (o_pin_high !== exp_seg.pin_high)
                    report("pin_high", exp_seg.pin_high, o_pin_high);
                if (o_hold_us !== exp_seg.hold_us)
                    report("hold_us", exp_seg.hold_us, o_hold_us);
                if (o_last !== exp_seg.last)
                    report("last", exp_seg.last, o_last);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (push && full === 1'b0) || (pop && empty === 1'b0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_addr  <= '0;
        i_cfg_data  <= '0;
        push        <= 1'b0;
        i_percent   <= '0;
        n_err       = 0;
        steady_flow = 1'b0;
        timing = '{detect_delay_us: 10'd150, detect_low_us: 10'd350,
                   mode_window_us: 10'd800, start_us: 10'd50, end_low_us: 10'd50,
                   short_us: 10'd50, long_us: 10'd100, device_address: 8'h72};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset timing: directed rows, then random
        for (int r = 0; r < N_ROWS; r++)
            send_pct(DIRECTED_ROWS[r].pct, DIRECTED_ROWS[r].lvl_known, DIRECTED_ROWS[r].lvl);
        send_random(ITEMS_PER_SET);
        settle();

        // every register at its top; address gets bits above its width
        foreach (reg_plan[k]) reg_plan[k] = '1;
        load_regs();
        send_pct(8'd255, 1'b1, 8'd31);
        send_pct(8'd0, 1'b1, 8'd0);
        send_random(ITEMS_PER_SET / 2);
        settle();
        send_random(ITEMS_PER_SET / 2);
        settle();

        // every register at zero, no idling on either side
        foreach (reg_plan[k]) reg_plan[k] = '0;
        load_regs();
        steady_flow = 1'b1;
        send_pct(8'd100, 1'b1, 8'd31);
        send_random(ITEMS_PER_SET);
        settle();
        steady_flow = 1'b0;

        repeat (2) begin
            foreach (reg_plan[k]) reg_plan[k] = 10'($urandom_range(0, 1023));
            load_regs();
            send_random(ITEMS_PER_SET);
            settle();
        end

        push <= 1'b0;
        while (segments_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_err == 0 && segments_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0t: %0d errors, %0d segments outstanding", $time, n_err,
                     segments_due.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
